// ===== src/assert_macros.svh =====
// Concurrent check macros; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/vbfe_pkg.sv =====
`default_nettype none
package vbfe_pkg;

   localparam int MAX_EXTENT = 64;
   localparam int COORD_W    = $clog2(MAX_EXTENT);
   localparam int ROW_ADDR_W = 2 * COORD_W;
   localparam int OCC_ROWS   = MAX_EXTENT * MAX_EXTENT;
   localparam int EXT_W      = 7;
   localparam int CFG_IDX_W  = 2;
   localparam int CORNER_W   = 8;
   localparam int SIDE_W     = 3;
   localparam int CNUM_W     = 2;
   localparam int NUM_SIDES  = 6;
   localparam int CMD_DEPTH  = 4;
   localparam int RSP_DEPTH  = 4;

   typedef logic [CFG_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_SIZE_X = 2'd0;
   localparam csr_idx_type CSR_SIZE_Y = 2'd1;
   localparam csr_idx_type CSR_SIZE_Z = 2'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef logic [SIDE_W-1:0] side_type;
   localparam side_type SIDE_XM = 3'd0;
   localparam side_type SIDE_XP = 3'd1;
   localparam side_type SIDE_YM = 3'd2;
   localparam side_type SIDE_YP = 3'd3;
   localparam side_type SIDE_ZM = 3'd4;
   localparam side_type SIDE_ZP = 3'd5;

   localparam logic [2:0] QUAD_CORNERS [NUM_SIDES][4] = '{
      '{3'd0, 3'd4, 3'd6, 3'd2},
      '{3'd3, 3'd7, 3'd5, 3'd1},
      '{3'd0, 3'd2, 3'd3, 3'd1},
      '{3'd5, 3'd7, 3'd6, 3'd4},
      '{3'd6, 3'd7, 3'd3, 3'd2},
      '{3'd1, 3'd5, 3'd4, 3'd0}
   };

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               filled;
      logic               in_range;
      logic               x_hi;
      logic               y_hi;
      logic               z_hi;
   } cmd_type;

   typedef struct packed {
      logic signed [CORNER_W-1:0] corner_x;
      logic signed [CORNER_W-1:0] corner_y;
      logic signed [CORNER_W-1:0] corner_z;
      logic [SIDE_W-1:0]          side;
      logic [CNUM_W-1:0]          corner_number;
      logic                       last_of_run;
   } rsp_type;

   function automatic logic [EXT_W-1:0] extent(input logic [EXT_W-1:0] raw);
      if (raw == '0) begin
         return EXT_W'(1);
      end else if (raw > EXT_W'(MAX_EXTENT)) begin
         return EXT_W'(MAX_EXTENT);
      end else begin
         return raw;
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/vbfe_front.sv =====
`default_nettype none
module vbfe_front import vbfe_pkg::*; (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_push,
   output logic                    req_full,
   input  wire                     req_kind,
   input  wire  [COORD_W-1:0]      req_vox_x,
   input  wire  [COORD_W-1:0]      req_vox_y,
   input  wire  [COORD_W-1:0]      req_vox_z,
   input  wire                     req_filled,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [CFG_IDX_W-1:0]    csr_index,
   input  wire  [EXT_W-1:0]        csr_data,
   input  wire                     cmd_full,
   input  wire                     clearing,
   output logic                    cmd_push,
   output cmd_type                 cmd
);

   logic [EXT_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [COORD_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic [COORD_W-1:0] cur_x_in, cur_y_in, cur_z_in;
   logic [EXT_W-1:0]   ext_x, ext_y, ext_z;
   logic [EXT_W-1:0]   nx, ny, nz;
   logic               x_hi, y_hi, z_hi, in_range;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full | clearing;
   assign cmd_push  = req_push & ~req_full;

   assign ext_x = extent(size_x_ff);
   assign ext_y = extent(size_y_ff);
   assign ext_z = extent(size_z_ff);
   assign nx    = {1'b0, cur_x_ff} + EXT_W'(1);
   assign ny    = {1'b0, cur_y_ff} + EXT_W'(1);
   assign nz    = {1'b0, cur_z_ff} + EXT_W'(1);
   assign x_hi  = nx >= ext_x;
   assign y_hi  = ny >= ext_y;
   assign z_hi  = nz >= ext_z;
   assign in_range = ({1'b0, cur_x_ff} < ext_x) && ({1'b0, cur_y_ff} < ext_y)
                     && ({1'b0, cur_z_ff} < ext_z);

   always_comb begin
      cmd.kind   = req_kind;
      cmd.filled = req_filled;
      if (req_kind == KIND_WRITE) begin
         cmd.x        = req_vox_x;
         cmd.y        = req_vox_y;
         cmd.z        = req_vox_z;
         cmd.in_range = 1'b0;
         cmd.x_hi     = 1'b0;
         cmd.y_hi     = 1'b0;
         cmd.z_hi     = 1'b0;
      end else begin
         cmd.x        = cur_x_ff;
         cmd.y        = cur_y_ff;
         cmd.z        = cur_z_ff;
         cmd.in_range = in_range;
         cmd.x_hi     = x_hi;
         cmd.y_hi     = y_hi;
         cmd.z_hi     = z_hi;
      end
   end

   // advance the raster cursor, x fastest
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_z_in = cur_z_ff;
      if (cmd_push && req_kind == KIND_STEP) begin
         if (x_hi) begin
            cur_x_in = '0;
            if (y_hi) begin
               cur_y_in = '0;
               cur_z_in = z_hi ? '0 : nz[COORD_W-1:0];
            end else begin
               cur_y_in = ny[COORD_W-1:0];
            end
         end else begin
            cur_x_in = nx[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= EXT_W'(MAX_EXTENT);
         size_y_ff <= EXT_W'(MAX_EXTENT);
         size_z_ff <= EXT_W'(MAX_EXTENT);
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         cur_z_ff  <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         cur_z_ff <= cur_z_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SIZE_X: size_x_ff <= csr_data;
               CSR_SIZE_Y: size_y_ff <= csr_data;
               CSR_SIZE_Z: size_z_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/vbfe_cmd_queue.sv =====
`default_nettype none
module vbfe_cmd_queue import vbfe_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      push,
   input  cmd_type  push_data,
   output logic     full,
   input  wire      pop,
   output logic     empty,
   output cmd_type  head
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            slots_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, wr_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full    = count_ff == CNT_W'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/vbfe_back.sv =====
`default_nettype none
module vbfe_back import vbfe_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      cmd_empty,
   input  cmd_type  cmd_head,
   output logic     cmd_pop,
   input  wire      rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp_data,
   output logic     clearing
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PLAN,
      ST_EMIT
   } state_type;

   localparam logic [2:0] RD_CENTER = 3'd0;
   localparam logic [2:0] RD_YM     = 3'd1;
   localparam logic [2:0] RD_YP     = 3'd2;
   localparam logic [2:0] RD_ZM     = 3'd3;
   localparam logic [2:0] RD_ZP     = 3'd4;

   state_type                 state_ff, state_in;
   logic [ROW_ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [2:0]                issue_ff, issue_in;
   logic [2:0]                rd_tag_ff, rd_tag_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      center_ff, center_in;
   logic [NUM_SIDES-1:0]      hit_ff, hit_in;
   logic [NUM_SIDES-1:0]      remain_ff, remain_in;
   logic [SIDE_W-1:0]         side_ff, side_in;
   logic [CNUM_W-1:0]         corner_ff, corner_in;

   logic [MAX_EXTENT-1:0]     occ_mem [OCC_ROWS];
   logic [MAX_EXTENT-1:0]     rd_data_ff;
   logic                      mem_we, mem_re;
   logic [ROW_ADDR_W-1:0]     mem_waddr, mem_raddr;
   logic [MAX_EXTENT-1:0]     mem_wmask, mem_wdata;

   logic [NUM_SIDES-1:0]      miss;
   logic [NUM_SIDES-1:0]      remain_next;
   logic [2:0]                corner_code;
   logic [COORD_W-1:0]        xm1, xp1;

   function automatic logic [SIDE_W-1:0] first_side(input logic [NUM_SIDES-1:0] mask);
      logic [SIDE_W-1:0] s;
      s = '0;
      for (int i = NUM_SIDES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            s = SIDE_W'(i);
         end
      end
      return s;
   endfunction

   function automatic logic [CORNER_W-1:0] doubled(input logic [COORD_W-1:0] v,
                                                   input logic plus);
      logic [CORNER_W-1:0] d;
      d = CORNER_W'({v, 1'b0});
      return plus ? d + CORNER_W'(1) : d - CORNER_W'(1);
   endfunction

   assign clearing    = state_ff == ST_CLEAR;
   assign miss        = ~hit_ff;
   assign remain_next = remain_ff & ~(NUM_SIDES'(1) << side_ff);
   assign corner_code = QUAD_CORNERS[side_ff][corner_ff];
   assign xm1         = cmd_ff.x - COORD_W'(1);
   assign xp1         = cmd_ff.x + COORD_W'(1);

   always_comb begin
      rsp_data.corner_x      = $signed(doubled(cmd_ff.x, corner_code[0]));
      rsp_data.corner_y      = $signed(doubled(cmd_ff.y, corner_code[2]));
      rsp_data.corner_z      = $signed(doubled(cmd_ff.z, ~corner_code[1]));
      rsp_data.side          = side_ff;
      rsp_data.corner_number = corner_ff;
      rsp_data.last_of_run   = (corner_ff == CNUM_W'(3)) && (remain_next == '0);
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cmd_in      = cmd_ff;
      issue_in    = issue_ff;
      rd_tag_in   = rd_tag_ff;
      rd_vld_in   = 1'b0;
      center_in   = center_ff;
      hit_in      = hit_ff;
      remain_in   = remain_ff;
      side_in     = side_ff;
      corner_in   = corner_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = '0;
      mem_raddr   = '0;
      mem_wmask   = '0;
      mem_wdata   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wmask   = '1;
            clr_addr_in = clr_addr_ff + ROW_ADDR_W'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_head.kind == KIND_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = {cmd_head.z, cmd_head.y};
                  mem_wmask = MAX_EXTENT'(1) << cmd_head.x;
                  mem_wdata = {MAX_EXTENT{cmd_head.filled}};
               end else if (cmd_head.in_range) begin
                  cmd_in   = cmd_head;
                  issue_in = RD_CENTER;
                  hit_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (issue_ff <= RD_ZP) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_tag_in = issue_ff;
               issue_in  = issue_ff + 3'd1;
               unique case (issue_ff)
                  RD_CENTER: mem_raddr = {cmd_ff.z, cmd_ff.y};
                  RD_YM:     mem_raddr = {cmd_ff.z, cmd_ff.y - COORD_W'(1)};
                  RD_YP:     mem_raddr = {cmd_ff.z, cmd_ff.y + COORD_W'(1)};
                  RD_ZM:     mem_raddr = {cmd_ff.z - COORD_W'(1), cmd_ff.y};
                  RD_ZP:     mem_raddr = {cmd_ff.z + COORD_W'(1), cmd_ff.y};
                  default:   mem_raddr = '0;
               endcase
            end
            if (rd_vld_ff) begin
               unique case (rd_tag_ff)
                  RD_CENTER: begin
                     center_in       = rd_data_ff[cmd_ff.x];
                     hit_in[SIDE_XM] = (cmd_ff.x != '0) && rd_data_ff[xm1];
                     hit_in[SIDE_XP] = !cmd_ff.x_hi && rd_data_ff[xp1];
                  end
                  RD_YM: hit_in[SIDE_YM] = (cmd_ff.y != '0) && rd_data_ff[cmd_ff.x];
                  RD_YP: hit_in[SIDE_YP] = !cmd_ff.y_hi && rd_data_ff[cmd_ff.x];
                  RD_ZM: hit_in[SIDE_ZM] = (cmd_ff.z != '0) && rd_data_ff[cmd_ff.x];
                  RD_ZP: begin
                     hit_in[SIDE_ZP] = !cmd_ff.z_hi && rd_data_ff[cmd_ff.x];
                     state_in        = ST_PLAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_PLAN: begin
            remain_in = miss;
            side_in   = first_side(miss);
            corner_in = '0;
            if (center_ff && miss != '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push  = 1'b1;
               corner_in = corner_ff + CNUM_W'(1);
               if (corner_ff == CNUM_W'(3)) begin
                  remain_in = remain_next;
                  side_in   = first_side(remain_next);
                  if (remain_next == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int i = 0; i < MAX_EXTENT; i++) begin
            if (mem_wmask[i]) begin
               occ_mem[mem_waddr][i] <= mem_wdata[i];
            end
         end
      end
      if (mem_re) begin
         rd_data_ff <= occ_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         rd_vld_ff   <= rd_vld_in;
         cmd_ff      <= cmd_in;
         issue_ff    <= issue_in;
         rd_tag_ff   <= rd_tag_in;
         center_ff   <= center_in;
         hit_ff      <= hit_in;
         remain_ff   <= remain_in;
         side_ff     <= side_in;
         corner_ff   <= corner_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/vbfe_rsp_queue.sv =====
`default_nettype none
module vbfe_rsp_queue import vbfe_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      push,
   input  rsp_type  push_data,
   output logic     full,
   input  wire      pop,
   output logic     empty,
   output rsp_type  head
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_type            slots_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, wr_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full    = count_ff == CNT_W'(RSP_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/voxel_boundary_face_extract.sv =====
// Flow: an accepted write waits in the command queue and lands in the bitmap when the idle back
// end dequeues it. Throughput: one write accepted per cycle while req_full is low; a step
// holds the back end for dequeue, five row reads from the single-port bitmap, one read drain
// and planning, then one emit per corner, up to 24, stalling while the response queue is full.
// Reset: synchronous, active high; afterwards a clearing pass zeroes the 4096-row bitmap one
// row per cycle, with req_full high throughout; size registers reset to 64.
`default_nettype none
`include "assert_macros.svh"
module voxel_boundary_face_extract import vbfe_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_push,
   output logic                       req_full,
   input  wire                        req_kind,
   input  wire  [COORD_W-1:0]         req_vox_x,
   input  wire  [COORD_W-1:0]         req_vox_y,
   input  wire  [COORD_W-1:0]         req_vox_z,
   input  wire                        req_filled,
   output logic                       rsp_empty,
   input  wire                        rsp_pop,
   output logic signed [CORNER_W-1:0] rsp_corner_x,
   output logic signed [CORNER_W-1:0] rsp_corner_y,
   output logic signed [CORNER_W-1:0] rsp_corner_z,
   output logic [SIDE_W-1:0]          rsp_side,
   output logic [CNUM_W-1:0]          rsp_corner_number,
   output logic                       rsp_last_of_run,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [CFG_IDX_W-1:0]       csr_index,
   input  wire  [EXT_W-1:0]           csr_data
);

   cmd_type cmd_in_data, cmd_head;
   rsp_type rsp_in_data, rsp_head;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic    rsp_push, rsp_full;
   logic    clearing;

   vbfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_kind   (req_kind),
      .req_vox_x  (req_vox_x),
      .req_vox_y  (req_vox_y),
      .req_vox_z  (req_vox_z),
      .req_filled (req_filled),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd_full   (cmd_full),
      .clearing   (clearing),
      .cmd_push   (cmd_push),
      .cmd        (cmd_in_data)
   );

   vbfe_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   vbfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data),
      .clearing  (clearing)
   );

   vbfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_corner_x      = rsp_head.corner_x;
   assign rsp_corner_y      = rsp_head.corner_y;
   assign rsp_corner_z      = rsp_head.corner_z;
   assign rsp_side          = rsp_head.side;
   assign rsp_corner_number = rsp_head.corner_number;
   assign rsp_last_of_run   = rsp_head.last_of_run;

   `ASSERT_IMPLY(a_clear_after_reset, clock, reset, $fell(reset), req_full)
   `ASSERT_IMPLY(a_cmd_pop_nonempty, clock, reset, cmd_pop, !cmd_empty)
   `ASSERT_IMPLY(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_full)
   `ASSERT_IMPLY(a_last_is_fourth, clock, reset, !rsp_empty && rsp_last_of_run, &rsp_corner_number)
   `ASSERT_NEXT(a_rsp_visible, clock, reset, rsp_push, !rsp_empty)

endmodule
`default_nettype wire
